// ----- rtl/core/linear_probe_hash_set_defines.svh -----
// Assertion macros for the hash set; each expects clk and rst_n in scope.
`ifndef LINEAR_PROBE_HASH_SET_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_DEFINES_SVH

`ifndef SYNTH
`define LPH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash set check failed");
`define LPH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash set check failed");
`else
`define LPH_ASSERT_SAME(lbl, ante, cons)
`define LPH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/lph_pkg.sv -----
`default_nettype none

package lph_pkg;

    localparam int KEY_W    = 31;
    localparam int SIZE_W   = 7;
    localparam int SLOT_W   = 6;
    localparam int MARK_W   = 2;
    localparam int BIT_W    = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_UPDATE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_FOUND  = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef struct packed {
        kind_t             kind;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  new_key;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } rsp_t;

    // Classified request handed from the front to the probe engine.
    typedef struct packed {
        kind_t             kind;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  new_key;
        logic [SIZE_W-1:0] home;
        logic [SIZE_W-1:0] new_home;
        logic [SIZE_W-1:0] size;
    } job_t;

    typedef struct packed {
        logic [MARK_W-1:0] mark;
        logic [KEY_W-1:0]  key;
    } entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/lph_ram.sv -----
`default_nettype none

module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/lph_queue.sv -----
`default_nettype none

module lph_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lph_pkg::job_t push_data,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output lph_pkg::job_t head
);

    localparam int PTR_W = $clog2(lph_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(lph_pkg::QUEUE_DEPTH + 1);

    lph_pkg::job_t      entry_reg [lph_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = (count_reg == CNT_W'(lph_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lph_front.sv -----
`default_nettype none

module lph_front #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         hold,
    input  lph_pkg::req_t                req,
    input  logic [lph_pkg::SIZE_W-1:0]   table_size,
    output logic                         busy,
    output logic                         push,
    output lph_pkg::job_t                job,
    input  logic                         full
);

    localparam int SW = lph_pkg::SIZE_W;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } state_t;

    state_t                         state_reg;
    lph_pkg::kind_t                 kind_reg;
    logic [lph_pkg::KEY_W-1:0]      key_reg;
    logic [lph_pkg::KEY_W-1:0]      new_key_reg;
    logic [SW-1:0]                  size_reg;
    logic [SW-1:0]                  rem_a_reg;
    logic [SW-1:0]                  rem_b_reg;
    logic [lph_pkg::BIT_W-1:0]      bit_reg;
    logic [SW-1:0]                  size_eff;

    // One restoring step: shift in the next dividend bit, subtract when it fits.
    function automatic logic [SW-1:0] mod_step(
        input logic [SW-1:0] rem,
        input logic          din,
        input logic [SW-1:0] div
    );
        logic [SW:0] t;
        t = {rem, din};
        if (t >= {1'b0, div})
        begin
            t = t - {1'b0, div};
        end
        return t[SW-1:0];
    endfunction

    always_comb
    begin
        size_eff = table_size;
        if (table_size == '0)
        begin
            size_eff = SW'(1);
        end
        else if (int'(table_size) > MAX_SLOTS)
        begin
            size_eff = SW'(MAX_SLOTS);
        end
    end

    assign busy = (state_reg != F_IDLE) || hold;
    assign push = (state_reg == F_PUSH) && !full;

    always_comb
    begin
        job.kind     = kind_reg;
        job.key      = key_reg;
        job.new_key  = new_key_reg;
        job.home     = rem_a_reg;
        job.new_home = rem_b_reg;
        job.size     = size_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            kind_reg    <= lph_pkg::KIND_INSERT;
            key_reg     <= '0;
            new_key_reg <= '0;
            size_reg    <= '0;
            rem_a_reg   <= '0;
            rem_b_reg   <= '0;
            bit_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (start && !hold)
                    begin
                        kind_reg    <= req.kind;
                        key_reg     <= req.key;
                        new_key_reg <= req.new_key;
                        size_reg    <= size_eff;
                        rem_a_reg   <= '0;
                        rem_b_reg   <= '0;
                        bit_reg     <= lph_pkg::BIT_W'(lph_pkg::KEY_W - 1);
                        state_reg   <= F_DIV;
                    end
                end
                F_DIV:
                begin
                    // both home slots at once, most significant key bit first
                    rem_a_reg <= mod_step(rem_a_reg, key_reg[bit_reg], size_reg);
                    rem_b_reg <= mod_step(rem_b_reg, new_key_reg[bit_reg], size_reg);
                    if (bit_reg == '0)
                    begin
                        state_reg <= F_PUSH;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                F_PUSH:
                begin
                    if (!full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lph_back.sv -----
`default_nettype none

module lph_back #(
    parameter int MAX_SLOTS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lph_pkg::job_t job,
    input  logic          empty,
    output logic          pop,
    output logic          clearing,
    output logic          done,
    output lph_pkg::rsp_t rsp
);

    localparam int SW   = lph_pkg::SIZE_W;
    localparam int IW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CMPW = (IW > SW) ? IW : SW;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_ISSUE,
        B_PROBE
    } state_t;

    state_t                     state_reg;
    lph_pkg::kind_t             kind_reg;
    logic [lph_pkg::KEY_W-1:0]  key_reg;
    logic [lph_pkg::KEY_W-1:0]  new_key_reg;
    logic [IW-1:0]              new_home_reg;
    logic [SW-1:0]              size_m1_reg;
    logic                       insert_reg;
    logic [IW-1:0]              p_reg;
    logic [IW-1:0]              at_reg;
    logic [SW-1:0]              cnt_reg;
    logic [IW-1:0]              clr_reg;
    logic                       done_reg;
    lph_pkg::rsp_t              rsp_reg;

    logic                       we;
    logic [IW-1:0]              waddr;
    lph_pkg::entry_t            wentry;
    logic [$bits(lph_pkg::entry_t)-1:0] rdata;
    lph_pkg::entry_t            rentry;
    logic [IW-1:0]              p_next;
    logic                       last;
    logic                       free_hit;
    logic                       key_hit;
    logic                       empty_hit;

    lph_ram #(
        .WIDTH ($bits(lph_pkg::entry_t)),
        .DEPTH (MAX_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (p_reg),
        .rdata (rdata)
    );

    assign rentry    = rdata;
    assign p_next    = (CMPW'(p_reg) == CMPW'(size_m1_reg)) ? '0 : p_reg + 1'b1;
    assign last      = (cnt_reg == size_m1_reg);
    assign free_hit  = (rentry.mark != lph_pkg::MARK_USED);
    assign empty_hit = (rentry.mark == lph_pkg::MARK_EMPTY);
    assign key_hit   = (rentry.mark == lph_pkg::MARK_USED) && (rentry.key == key_reg);

    assign pop      = (state_reg == B_IDLE) && !empty;
    assign clearing = (state_reg == B_CLEAR);
    assign done     = done_reg;
    assign rsp      = rsp_reg;

    always_comb
    begin
        we          = 1'b0;
        waddr       = at_reg;
        wentry.mark = lph_pkg::MARK_USED;
        wentry.key  = key_reg;
        case (state_reg)
            B_CLEAR:
            begin
                we          = 1'b1;
                waddr       = clr_reg;
                wentry.mark = lph_pkg::MARK_EMPTY;
                wentry.key  = '0;
            end
            B_PROBE:
            begin
                if (insert_reg)
                begin
                    we = free_hit;
                end
                else if (!empty_hit && key_hit &&
                         (kind_reg == lph_pkg::KIND_REMOVE ||
                          kind_reg == lph_pkg::KIND_UPDATE))
                begin
                    we          = 1'b1;
                    wentry.mark = lph_pkg::MARK_DELETED;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_CLEAR;
            kind_reg     <= lph_pkg::KIND_INSERT;
            key_reg      <= '0;
            new_key_reg  <= '0;
            new_home_reg <= '0;
            size_m1_reg  <= '0;
            insert_reg   <= 1'b0;
            p_reg        <= '0;
            at_reg       <= '0;
            cnt_reg      <= '0;
            clr_reg      <= '0;
            done_reg     <= 1'b0;
            rsp_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                B_CLEAR:
                begin
                    if (clr_reg == IW'(MAX_SLOTS - 1))
                    begin
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + 1'b1;
                    end
                end
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        kind_reg     <= job.kind;
                        key_reg      <= job.key;
                        new_key_reg  <= job.new_key;
                        new_home_reg <= IW'(job.new_home);
                        size_m1_reg  <= job.size - 1'b1;
                        p_reg        <= IW'(job.home);
                        cnt_reg      <= '0;
                        insert_reg   <= (job.kind == lph_pkg::KIND_INSERT);
                        state_reg    <= B_ISSUE;
                    end
                end
                B_ISSUE:
                begin
                    at_reg    <= p_reg;
                    p_reg     <= p_next;
                    state_reg <= B_PROBE;
                end
                B_PROBE:
                begin
                    // keep one read in flight; drop it when the walk stops
                    at_reg <= p_reg;
                    p_reg  <= p_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (insert_reg)
                    begin
                        if (free_hit)
                        begin
                            done_reg       <= 1'b1;
                            rsp_reg.status <= lph_pkg::ST_DONE;
                            rsp_reg.slot   <= lph_pkg::SLOT_W'(at_reg);
                            state_reg      <= B_IDLE;
                        end
                        else if (last)
                        begin
                            done_reg       <= 1'b1;
                            rsp_reg.status <= lph_pkg::ST_FULL;
                            rsp_reg.slot   <= '0;
                            state_reg      <= B_IDLE;
                        end
                    end
                    else if (empty_hit)
                    begin
                        done_reg       <= 1'b1;
                        rsp_reg.status <= lph_pkg::ST_ABSENT;
                        rsp_reg.slot   <= '0;
                        state_reg      <= B_IDLE;
                    end
                    else if (key_hit)
                    begin
                        case (kind_reg)
                            lph_pkg::KIND_SEARCH:
                            begin
                                done_reg       <= 1'b1;
                                rsp_reg.status <= lph_pkg::ST_FOUND;
                                rsp_reg.slot   <= lph_pkg::SLOT_W'(at_reg);
                                state_reg      <= B_IDLE;
                            end
                            lph_pkg::KIND_UPDATE:
                            begin
                                // old key marked deleted this cycle; walk again for the new key
                                insert_reg <= 1'b1;
                                key_reg    <= new_key_reg;
                                p_reg      <= new_home_reg;
                                cnt_reg    <= '0;
                                state_reg  <= B_ISSUE;
                            end
                            default:
                            begin
                                done_reg       <= 1'b1;
                                rsp_reg.status <= lph_pkg::ST_DONE;
                                rsp_reg.slot   <= lph_pkg::SLOT_W'(at_reg);
                                state_reg      <= B_IDLE;
                            end
                        endcase
                    end
                    else if (last)
                    begin
                        done_reg       <= 1'b1;
                        rsp_reg.status <= lph_pkg::ST_ABSENT;
                        rsp_reg.slot   <= '0;
                        state_reg      <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/linear_probe_hash_set.sv -----
`default_nettype none

`include "linear_probe_hash_set_defines.svh"

// Linear-probing hash set with MAX_SLOTS key slots. A request is taken when
// start is high and busy is low; each request gives exactly one result beat,
// shown on rsp for one cycle with done high, and the receiver cannot stall it.
// After reset the slot memory is swept to empty, one slot per cycle, and busy
// stays high until the sweep is over. The front computes the home slots (key
// and new key together) one key bit per cycle, then hands the job off; the
// probe engine then walks the slots from the home slot, fed by the slot
// memory's registered read, and an update that finds its key adds a second
// walk for the new key. Front and probe engine overlap across requests through
// a two-entry queue, so sustained rate is set by the slower of the two.
// table_size is to be written only while idle by the user; the block itself
// does not enforce it. 0 acts as 1, values above MAX_SLOTS act as MAX_SLOTS.
module linear_probe_hash_set #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lph_pkg::req_t              req,
    output logic                       done,
    output lph_pkg::rsp_t              rsp,
    input  logic                       cfg_we,
    input  logic [lph_pkg::SIZE_W-1:0] cfg_wdata
);

    logic [lph_pkg::SIZE_W-1:0] table_size_reg;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_full;
    logic                       q_empty;
    lph_pkg::job_t              q_in;
    lph_pkg::job_t              q_head;
    logic                       clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= lph_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            table_size_reg <= cfg_wdata;
        end
    end

    lph_front #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .hold       (clearing),
        .req        (req),
        .table_size (table_size_reg),
        .busy       (busy),
        .push       (q_push),
        .job        (q_in),
        .full       (q_full)
    );

    lph_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    lph_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .clearing (clearing),
        .done     (done),
        .rsp      (rsp)
    );

    // a miss or a full table never reports a slot
    `LPH_ASSERT_SAME(a_slot_zero_on_miss,
        done && (rsp.status == lph_pkg::ST_FULL || rsp.status == lph_pkg::ST_ABSENT),
        rsp.slot == '0)
    // the walk always passes through idle and issue, so results never land back to back
    `LPH_ASSERT_NEXT(a_done_spaced, done, !done)
    `LPH_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
    `LPH_ASSERT_SAME(a_no_pop_while_clearing, clearing, !q_pop)

endmodule

`default_nettype wire
